// File: hw/rtl/rgbbp_pkg.sv
// Shared types, palette table and attribute codes for the bitplane packer.
`timescale 1ns / 1ps

package rgbbp_pkg;

   // Geometry of one word
   localparam int PIXELS_PER_BYTE = 8;
   localparam int PIXEL_W         = 24;
   localparam int BYTE_W          = 8;
   localparam int PALETTE_SIZE    = 7;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_MODE_COLORS = 1'b0;  // word address bit of mode_colors

   typedef logic [PIXEL_W-1:0] pixel_type;
   typedef logic [BYTE_W-1:0]  attr_type;

   // Attribute codes
   localparam attr_type ATTR_WHITE   = 8'h00;
   localparam attr_type ATTR_YELLOW  = 8'h10;
   localparam attr_type ATTR_MAGENTA = 8'h40;
   localparam attr_type ATTR_RED     = 8'h50;
   localparam attr_type ATTR_CYAN    = 8'h80;
   localparam attr_type ATTR_GREEN   = 8'h90;
   localparam attr_type ATTR_BLUE    = 8'hC0;

   // Palette, in byte-swapped pixel order, with matching codes
   localparam pixel_type PALETTE_COLOR [PALETTE_SIZE] = '{
      24'hFFFFFF, 24'hFFFF00, 24'hFF00FF, 24'hFF0000,
      24'h00FFFF, 24'h00FF00, 24'h0000FF
   };
   localparam attr_type PALETTE_ATTR [PALETTE_SIZE] = '{
      ATTR_WHITE, ATTR_YELLOW, ATTR_MAGENTA, ATTR_RED,
      ATTR_CYAN, ATTR_GREEN, ATTR_BLUE
   };

   // Result of matching one word against the palette
   typedef struct packed {
      logic                     any;     // at least one pixel matched
      attr_type                 attr;    // run attribute, valid when any
      logic [BYTE_W-1:0]        bitmap;  // pixel_a in bit 7
   } match_type;

endpackage

// File: hw/rtl/rgbbp_req_if.sv
// Input channel: eight raw pixels and the tile start flag.
`timescale 1ns / 1ps

interface rgbbp_req_if;
   import rgbbp_pkg::*;

   logic      valid;
   logic      ready;
   pixel_type pixel_a;
   pixel_type pixel_b;
   pixel_type pixel_c;
   pixel_type pixel_d;
   pixel_type pixel_e;
   pixel_type pixel_f;
   pixel_type pixel_g;
   pixel_type pixel_h;
   logic      tile_start;

   modport source (
      output valid, pixel_a, pixel_b, pixel_c, pixel_d,
             pixel_e, pixel_f, pixel_g, pixel_h, tile_start,
      input  ready
   );
   modport sink (
      input  valid, pixel_a, pixel_b, pixel_c, pixel_d,
             pixel_e, pixel_f, pixel_g, pixel_h, tile_start,
      output ready
   );
endinterface

// File: hw/rtl/rgbbp_rsp_if.sv
// Result channel: bitmap byte, color attribute and its valid flag.
`timescale 1ns / 1ps

interface rgbbp_rsp_if;
   import rgbbp_pkg::*;

   logic     valid;
   logic     ready;
   logic [BYTE_W-1:0] bitmap_byte;
   attr_type color_attr;
   logic     color_valid;

   modport source (
      output valid, bitmap_byte, color_attr, color_valid,
      input  ready
   );
   modport sink (
      input  valid, bitmap_byte, color_attr, color_valid,
      output ready
   );
endinterface

// File: hw/rtl/rgb_to_bitplane_color_packer.sv
// Top level: input register, palette match, held attribute and result register.
//
//  channel  | dir | handshake      | word
//  ---------+-----+----------------+--------------------------------------------
//  req_ch   | in  | valid/ready    | pixel_a..pixel_h (24b each), tile_start
//  rsp_ch   | out | valid/ready    | bitmap_byte, color_attr, color_valid
//  csr_*    | in  | APB, pready=1  | word 0: mode_colors (bit 0)
//
// One word per clock sustained while rsp_ch keeps ready high; an accepted word
// passes through the input register, then the result register, before it
// shows on rsp_ch. The held attribute is updated as a word moves into the
// result register, so consecutive words see each other's attribute with no
// gap. Synchronous active-high reset clears the valid flags, the held
// attribute and mode_colors. A stalled result holds in place while one more
// word can still wait in the input register.
`timescale 1ns / 1ps

module rgb_to_bitplane_color_packer
   import rgbbp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   rgbbp_req_if.sink             req_ch,
   rgbbp_rsp_if.source           rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic      mode_colors;

   // Input stage
   logic      s1_valid_ff;
   logic      s1_valid_in;
   pixel_type s1_pix_ff [PIXELS_PER_BYTE];
   logic      s1_tile_ff;

   // Result stage
   logic              out_valid_ff;
   logic              out_valid_in;
   logic [BYTE_W-1:0] bitmap_ff;
   logic              cvalid_ff;
   attr_type          held_attr_ff;
   attr_type          held_attr_in;
   attr_type          held_base;

   logic      req_fire;
   logic      advance;
   match_type match;

   rgbbp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (csr_psel),
      .penable     (csr_penable),
      .pwrite      (csr_pwrite),
      .paddr       (csr_paddr),
      .pwdata      (csr_pwdata),
      .prdata      (csr_prdata),
      .pready      (csr_pready),
      .mode_colors (mode_colors)
   );

   rgbbp_match u_match (
      .pixels (s1_pix_ff),
      .result (match)
   );

   // Flow control
   assign advance       = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready  = !s1_valid_ff || advance;
   assign req_fire      = req_ch.valid && req_ch.ready;

   assign s1_valid_in   = req_fire || (s1_valid_ff && !advance);
   assign out_valid_in  = advance || (out_valid_ff && !rsp_ch.ready);

   // Held attribute: cleared at tile start, replaced by a matched run
   assign held_base    = s1_tile_ff ? ATTR_WHITE : held_attr_ff;
   assign held_attr_in = match.any ? match.attr : held_base;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         held_attr_ff <= ATTR_WHITE;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            held_attr_ff <= held_attr_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_pix_ff[0] <= req_ch.pixel_a;
         s1_pix_ff[1] <= req_ch.pixel_b;
         s1_pix_ff[2] <= req_ch.pixel_c;
         s1_pix_ff[3] <= req_ch.pixel_d;
         s1_pix_ff[4] <= req_ch.pixel_e;
         s1_pix_ff[5] <= req_ch.pixel_f;
         s1_pix_ff[6] <= req_ch.pixel_g;
         s1_pix_ff[7] <= req_ch.pixel_h;
         s1_tile_ff   <= req_ch.tile_start;
      end
      if (advance) begin
         bitmap_ff <= match.bitmap;
         cvalid_ff <= mode_colors;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.bitmap_byte = bitmap_ff;
   assign rsp_ch.color_attr  = held_attr_ff;
   assign rsp_ch.color_valid = cvalid_ff;

   // Checks
   a_held_legal: assert property (@(posedge clock) disable iff (reset)
      held_attr_ff == ATTR_WHITE || held_attr_ff == ATTR_YELLOW ||
      held_attr_ff == ATTR_MAGENTA || held_attr_ff == ATTR_RED ||
      held_attr_ff == ATTR_CYAN || held_attr_ff == ATTR_GREEN ||
      held_attr_ff == ATTR_BLUE)
      else $error("held attribute left the code set");

   a_tile_clear: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_tile_ff && !match.any) |=> (held_attr_ff == ATTR_WHITE))
      else $error("empty run after tile start did not clear the attribute");

   a_empty_keeps: assert property (@(posedge clock) disable iff (reset)
      (advance && !s1_tile_ff && !match.any) |=> $stable(held_attr_ff))
      else $error("empty run changed the held attribute");

   a_bitmap_any: assert property (@(posedge clock) disable iff (reset)
      advance |=> ((rsp_ch.bitmap_byte != '0) == $past(match.any)))
      else $error("bitmap and match flag disagree");

endmodule

// File: hw/rtl/rgbbp_match.sv
// Palette match of eight pixels: bitmap byte and run attribute.
`timescale 1ns / 1ps

module rgbbp_match
   import rgbbp_pkg::*;
(
   input  pixel_type pixels [PIXELS_PER_BYTE],
   output match_type result
);

   logic     hit  [PIXELS_PER_BYTE];
   attr_type code [PIXELS_PER_BYTE];

   // Per pixel: swap low and high bytes, then look up the palette
   always_comb begin
      pixel_type sw;
      for (int p = 0; p < PIXELS_PER_BYTE; p++) begin
         sw      = {pixels[p][7:0], pixels[p][15:8], pixels[p][23:16]};
         hit[p]  = 1'b0;
         code[p] = ATTR_WHITE;
         for (int k = 0; k < PALETTE_SIZE; k++) begin
            if (sw == PALETTE_COLOR[k]) begin
               hit[p]  = 1'b1;
               code[p] = PALETTE_ATTR[k];
            end
         end
      end
   end

   // Bitmap, leftmost pixel in the top bit; attribute is the first
   // non-white match, or white when only white pixels matched
   always_comb begin
      logic found_color;
      found_color   = 1'b0;
      result.any    = 1'b0;
      result.attr   = ATTR_WHITE;
      result.bitmap = '0;
      for (int p = 0; p < PIXELS_PER_BYTE; p++) begin
         result.bitmap[PIXELS_PER_BYTE-1-p] = hit[p];
         if (hit[p]) begin
            result.any = 1'b1;
            if (!found_color && code[p] != ATTR_WHITE) begin
               found_color = 1'b1;
               result.attr = code[p];
            end
         end
      end
   end

endmodule

// File: hw/rtl/rgbbp_csr.sv
// APB-style configuration register: mode_colors.
`timescale 1ns / 1ps

module rgbbp_csr
   import rgbbp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic                  mode_colors
);

   logic mode_colors_ff;
   logic mode_colors_in;
   logic sel_mode;

   assign sel_mode = (paddr[CSR_ADDR_W-1] == CSR_IDX_MODE_COLORS);

   // Write on the access phase
   always_comb begin
      mode_colors_in = mode_colors_ff;
      if (psel && penable && pwrite && sel_mode) begin
         mode_colors_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_colors_ff <= 1'b0;
      end else begin
         mode_colors_ff <= mode_colors_in;
      end
   end

   // Read back; unused addresses read zero
   assign prdata      = sel_mode ? {{(CSR_DATA_W-1){1'b0}}, mode_colors_ff} : '0;
   assign pready      = 1'b1;
   assign mode_colors = mode_colors_ff;

endmodule

// File: dv/tb_top.sv
// Self-checking bench for the eight-pixel bitmap and color attribute packer.
`timescale 1ns / 1ps

module tb_top;
   import rgbbp_pkg::*;

   // One input word: eight raw pixels (index 0 is pixel_a) plus the tile start flag
   typedef struct packed {
      logic                            tile_start;
      pixel_type [0:PIXELS_PER_BYTE-1] px;
   } run_type;

   // One output word
   typedef struct packed {
      logic [BYTE_W-1:0] bitmap;
      attr_type          attr;
      logic              color_valid;
   } packed_word_type;

   // Directed row; when typed is set the listed bitmap/attr is the expectation
   typedef struct packed {
      run_type           run;
      logic              typed;
      logic [BYTE_W-1:0] bitmap;
      attr_type          attr;
   } dir_row_type;

   // Raw pixel words whose byte-swapped value hits the palette
   localparam pixel_type RAW_BLACK   = 24'h000000;
   localparam pixel_type RAW_WHITE   = 24'hFFFFFF;
   localparam pixel_type RAW_YELLOW  = 24'h00FFFF;
   localparam pixel_type RAW_MAGENTA = 24'hFF00FF;
   localparam pixel_type RAW_RED     = 24'h0000FF;
   localparam pixel_type RAW_CYAN    = 24'hFFFF00;
   localparam pixel_type RAW_GREEN   = 24'h00FF00;
   localparam pixel_type RAW_BLUE    = 24'hFF0000;
   localparam pixel_type RAW_PALETTE [PALETTE_SIZE] = '{
      RAW_WHITE, RAW_YELLOW, RAW_MAGENTA, RAW_RED, RAW_CYAN, RAW_GREEN, RAW_BLUE
   };

   localparam logic [CSR_ADDR_W-1:0] MODE_COLORS_ADDR =
      CSR_ADDR_W'({CSR_IDX_MODE_COLORS, 2'b00});

   localparam int WORDS_PER_PHASE = 170;
   localparam bit COLORS_SCHEDULE [3] = '{1'b1, 1'b0, 1'b1};
   localparam int HOLD_AT_WORD    = 120;
   localparam int HOLD_CYCLES     = 150;
   localparam int MAX_IDLE        = 10;

   // Directed words, run with colors off straight out of reset
   localparam int DIR_ROWS = 17;
   localparam dir_row_type DIRECTED [DIR_ROWS] = '{
      // empty run right after reset
      '{'{1'b0, '{RAW_BLACK, RAW_BLACK, RAW_BLACK, RAW_BLACK,
                  RAW_BLACK, RAW_BLACK, RAW_BLACK, RAW_BLACK}}, 1'b1, 8'h00, ATTR_WHITE},
      // all white
      '{'{1'b0, '{RAW_WHITE, RAW_WHITE, RAW_WHITE, RAW_WHITE,
                  RAW_WHITE, RAW_WHITE, RAW_WHITE, RAW_WHITE}}, 1'b1, 8'hFF, ATTR_WHITE},
      // white first, then red replaces it
      '{'{1'b0, '{RAW_WHITE, RAW_RED, RAW_BLACK, RAW_BLACK,
                  RAW_BLACK, RAW_BLACK, RAW_BLACK, RAW_BLACK}}, 1'b1, 8'hC0, ATTR_RED},
      // empty run repeats the held attribute
      '{'{1'b0, '{RAW_BLACK, RAW_BLACK, RAW_BLACK, RAW_BLACK,
                  RAW_BLACK, RAW_BLACK, RAW_BLACK, RAW_BLACK}}, 1'b1, 8'h00, ATTR_RED},
      // tile start clears it
      '{'{1'b1, '{RAW_BLACK, RAW_BLACK, RAW_BLACK, RAW_BLACK,
                  RAW_BLACK, RAW_BLACK, RAW_BLACK, RAW_BLACK}}, 1'b1, 8'h00, ATTR_WHITE},
      // rightmost pixel only
      '{'{1'b0, '{RAW_BLACK, RAW_BLACK, RAW_BLACK, RAW_BLACK,
                  RAW_BLACK, RAW_BLACK, RAW_BLACK, RAW_BLUE}}, 1'b1, 8'h01, ATTR_BLUE},
      // first non-white color wins over later ones
      '{'{1'b0, '{RAW_YELLOW, RAW_WHITE, RAW_GREEN, RAW_BLACK,
                  RAW_BLACK, RAW_BLACK, RAW_BLACK, RAW_BLACK}}, 1'b1, 8'hE0, ATTR_YELLOW},
      // tile start plus a hit; raw FFFF00 swaps to cyan
      '{'{1'b1, '{RAW_CYAN, RAW_BLACK, RAW_BLACK, RAW_BLACK,
                  RAW_BLACK, RAW_BLACK, RAW_BLACK, RAW_BLACK}}, 1'b1, 8'h80, ATTR_CYAN},
      '{'{1'b0, '{RAW_MAGENTA, RAW_MAGENTA, RAW_MAGENTA, RAW_MAGENTA,
                  RAW_MAGENTA, RAW_MAGENTA, RAW_MAGENTA, RAW_MAGENTA}},
        1'b1, 8'hFF, ATTR_MAGENTA},
      // near misses, one bit or byte order off
      '{'{1'b0, '{24'hFFFFFE, 24'h7FFFFF, 24'hFEFFFF, 24'h00FFFE,
                  24'h000001, 24'h0100FF, 24'hFFFF01, 24'h010000}},
        1'b1, 8'h00, ATTR_MAGENTA},
      // whole palette in one run
      '{'{1'b0, '{RAW_WHITE, RAW_YELLOW, RAW_MAGENTA, RAW_RED,
                  RAW_CYAN, RAW_GREEN, RAW_BLUE, RAW_BLACK}}, 1'b1, 8'hFE, ATTR_YELLOW},
      '{'{1'b0, '{RAW_WHITE, RAW_WHITE, RAW_BLACK, RAW_BLACK,
                  RAW_BLACK, RAW_BLACK, RAW_BLACK, RAW_GREEN}}, 1'b1, 8'hC1, ATTR_GREEN},
      '{'{1'b1, '{RAW_WHITE, RAW_WHITE, RAW_WHITE, RAW_WHITE,
                  RAW_WHITE, RAW_WHITE, RAW_WHITE, RAW_WHITE}}, 1'b1, 8'hFF, ATTR_WHITE},
      '{'{1'b0, '{RAW_RED, RAW_RED, RAW_RED, RAW_RED,
                  RAW_RED, RAW_RED, RAW_RED, RAW_RED}}, 1'b1, 8'hFF, ATTR_RED},
      // a lone white hit overwrites the held color
      '{'{1'b0, '{RAW_WHITE, RAW_BLACK, RAW_BLACK, RAW_BLACK,
                  RAW_BLACK, RAW_BLACK, RAW_BLACK, RAW_BLACK}}, 1'b1, 8'h80, ATTR_WHITE},
      // mixed patterns, left to the predictor
      '{'{1'b0, '{24'h123456, 24'hABCDEF, 24'h5A5A5A, 24'hA5A5A5,
                  24'h0F0F0F, 24'hF0F0F0, 24'h800000, 24'h000080}}, 1'b0, 8'h00, ATTR_WHITE},
      '{'{1'b1, '{RAW_BLUE, 24'h7F7F7F, RAW_RED, RAW_WHITE,
                  24'h3C3C3C, RAW_GREEN, 24'hC3C3C3, RAW_CYAN}}, 1'b0, 8'h00, ATTR_WHITE}
   };

   logic clock = 1'b0;
   logic reset;

   rgbbp_req_if req_ch ();
   rgbbp_rsp_if rsp_ch ();

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   rgb_to_bitplane_color_packer dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predictor state and bookkeeping
   attr_type        tile_attr;
   logic            colors_on;
   packed_word_type pending_bytes [$];
   int              fail_count = 0;
   int              sent_count = 0;
   int              got_count  = 0;

   // Byte swap, then palette match
   function automatic logic palette_lookup(input pixel_type raw, output attr_type code);
      pixel_type swapped;
      swapped = {raw[7:0], raw[15:8], raw[23:16]};
      palette_lookup = 1'b1;
      code           = ATTR_WHITE;
      case (swapped)
         24'hFFFFFF: code = ATTR_WHITE;
         24'hFFFF00: code = ATTR_YELLOW;
         24'hFF00FF: code = ATTR_MAGENTA;
         24'hFF0000: code = ATTR_RED;
         24'h00FFFF: code = ATTR_CYAN;
         24'h00FF00: code = ATTR_GREEN;
         24'h0000FF: code = ATTR_BLUE;
         default:    palette_lookup = 1'b0;
      endcase
   endfunction

   // Bitmap and attribute for one run; updates the held attribute
   function automatic packed_word_type pack_run(input run_type w);
      packed_word_type r;
      attr_type        code;
      attr_type        run_attr;
      logic            hit;
      logic            have_attr;
      int              i;
      if (w.tile_start) tile_attr = '0;
      r.bitmap  = '0;
      run_attr  = '0;
      have_attr = 1'b0;
      for (i = 0; i < PIXELS_PER_BYTE; i++) begin
         hit = palette_lookup(w.px[i], code);
         r.bitmap = {r.bitmap[BYTE_W-2:0], hit};
         // white only holds until some other color shows up
         if (hit && (!have_attr || run_attr == ATTR_WHITE)) begin
            run_attr  = code;
            have_attr = 1'b1;
         end
      end
      if (have_attr) tile_attr = run_attr;
      r.attr        = tile_attr;
      r.color_valid = colors_on;
      return r;
   endfunction

   function automatic int idle_cycles(input bit quiet);
      return quiet ? 0 : $urandom_range(0, MAX_IDLE);
   endfunction

   // Mostly palette hits, some black, near misses and raw noise
   function automatic pixel_type draw_pixel();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return RAW_PALETTE[$urandom_range(0, PALETTE_SIZE-1)];
      if (pick < 65) return RAW_BLACK;
      if (pick < 80)
         return RAW_PALETTE[$urandom_range(0, PALETTE_SIZE-1)] ^
                (24'h1 << $urandom_range(0, PIXEL_W-1));
      return pixel_type'($urandom);
   endfunction

   function automatic run_type draw_run();
      run_type w;
      int      i;
      w.tile_start = ($urandom_range(0, 7) == 0);
      for (i = 0; i < PIXELS_PER_BYTE; i++) w.px[i] = draw_pixel();
      return w;
   endfunction

   // Offer one word, wait for acceptance, then record its expectation
   task automatic send_word(input run_type w, input logic typed,
                            input logic [BYTE_W-1:0] t_bitmap, input attr_type t_attr);
      packed_word_type p;
      int              gap;
      gap = idle_cycles(((sent_count / 40) % 3) == 2);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.pixel_a    <= w.px[0];
      req_ch.pixel_b    <= w.px[1];
      req_ch.pixel_c    <= w.px[2];
      req_ch.pixel_d    <= w.px[3];
      req_ch.pixel_e    <= w.px[4];
      req_ch.pixel_f    <= w.px[5];
      req_ch.pixel_g    <= w.px[6];
      req_ch.pixel_h    <= w.px[7];
      req_ch.tile_start <= w.tile_start;
      do @(posedge clock); while (!req_ch.ready);
      p = pack_run(w);
      if (typed) begin
         p.bitmap = t_bitmap;
         p.attr   = t_attr;
      end
      pending_bytes = {pending_bytes, p};
      sent_count++;
   endtask

   task automatic drain();
      while (pending_bytes.size() != 0) @(posedge clock);
   endtask

   // Read mode_colors back and compare with the predictor's copy
   task automatic verify_mode_colors();
      logic [CSR_DATA_W-1:0] rd;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= MODE_COLORS_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rd = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (rd !== CSR_DATA_W'(colors_on)) begin
         $display("%0t ns: mode_colors readback expected %0h got %0h",
                  $time, colors_on, rd);
         fail_count++;
      end
   endtask

   task automatic set_mode_colors(input logic on);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= MODE_COLORS_ADDR;
      csr_pwdata  <= CSR_DATA_W'(on);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      colors_on = on;
      verify_mode_colors();
   endtask

   // Stimulus: reset, directed table, then random phases with color mode changes
   initial begin : stimulus
      int i;
      int ph;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.pixel_a    <= '0;
      req_ch.pixel_b    <= '0;
      req_ch.pixel_c    <= '0;
      req_ch.pixel_d    <= '0;
      req_ch.pixel_e    <= '0;
      req_ch.pixel_f    <= '0;
      req_ch.pixel_g    <= '0;
      req_ch.pixel_h    <= '0;
      req_ch.tile_start <= 1'b0;
      csr_psel          <= 1'b0;
      csr_penable       <= 1'b0;
      csr_pwrite        <= 1'b0;
      csr_paddr         <= '0;
      csr_pwdata        <= '0;
      tile_attr = '0;
      colors_on = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      verify_mode_colors();
      for (i = 0; i < DIR_ROWS; i++)
         send_word(DIRECTED[i].run, DIRECTED[i].typed, DIRECTED[i].bitmap, DIRECTED[i].attr);
      req_ch.valid <= 1'b0;
      drain();

      for (ph = 0; ph < 3; ph++) begin
         set_mode_colors(COLORS_SCHEDULE[ph]);
         for (i = 0; i < WORDS_PER_PHASE; i++) send_word(draw_run(), 1'b0, '0, '0);
         req_ch.valid <= 1'b0;
         drain();
      end

      // two-stage pipe; leave room for any stray word
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Result side: random stalls, one long hold-off, compare with oldest expectation
   initial begin : result_side
      int              stall;
      bit              held_off;
      packed_word_type want;
      held_off = 1'b0;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (got_count == HOLD_AT_WORD && !held_off) begin
            stall    = HOLD_CYCLES;
            held_off = 1'b1;
         end else begin
            stall = idle_cycles(((got_count / 40) % 3) == 1);
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         if (pending_bytes.size() == 0) begin
            $display("%0t ns: unexpected word bitmap %02h attr %02h color_valid %b",
                     $time, rsp_ch.bitmap_byte, rsp_ch.color_attr, rsp_ch.color_valid);
            fail_count++;
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_ch.bitmap_byte !== want.bitmap || rsp_ch.color_attr !== want.attr ||
                rsp_ch.color_valid !== want.color_valid) begin
               $display("%0t ns: expected bitmap %02h attr %02h color_valid %b, got %02h %02h %b",
                        $time, want.bitmap, want.attr, want.color_valid,
                        rsp_ch.bitmap_byte, rsp_ch.color_attr, rsp_ch.color_valid);
               fail_count++;
            end
         end
         got_count++;
      end
   end

   // Hang guard
   initial begin : watchdog
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
